### rtl/bitmap_byte_suppressor_defines.svh
// ----------------------------------------------------------------------------
// bitmap byte suppressor assertion macros
// concurrent checks that compile away when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef BITMAP_BYTE_SUPPRESSOR_DEFINES_SVH
`define BITMAP_BYTE_SUPPRESSOR_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication check failed");

`else

`define ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

### rtl/bbs_pkg.sv
// ----------------------------------------------------------------------------
// bbs_pkg
// payload types, command and output kind codes and sequencer states of the suppressor
// ----------------------------------------------------------------------------
`default_nettype none

package bbs_pkg;

	// group geometry
	localparam int unsigned GROUP_SIZE = 8;
	localparam int unsigned IDX_W      = $clog2(GROUP_SIZE);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GROUP_SIZE - 1);

	// end marker base value
	localparam logic [7:0] END_MARK_BASE = 8'h30;

	// command codes
	localparam logic CMD_DATA  = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// output kind codes
	localparam logic [1:0] KIND_MAP = 2'd0;
	localparam logic [1:0] KIND_LIT = 2'd1;
	localparam logic [1:0] KIND_RAW = 2'd2;
	localparam logic [1:0] KIND_END = 2'd3;

	// input item
	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [1:0] out_kind;
		logic [7:0] out_byte;
		logic       last;
	} out_item_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAP,
		ST_SCAN,
		ST_MARK
	} seq_state_t;

endpackage

`default_nettype wire

### rtl/bitmap_byte_suppressor.sv
// ----------------------------------------------------------------------------
// bitmap_byte_suppressor
// packs bytes in groups of eight behind a presence map, dropping the
// suppressed value; flush emits the partial group raw and an end marker
// ----------------------------------------------------------------------------
//
//  channel   direction  signals                       transfer when
//  src       in         src_valid src_ready src_item  src_valid & src_ready
//  dst       out        dst_valid dst_ready dst_item  dst_valid & dst_ready
//  cfg       in         cfg_we cfg_wdata              cfg_we
//
// a data byte that completes no group sends nothing; a completed group sends its
// map, then each kept literal, the store giving one entry a cycle while the read
// stage is free; a flush sends each tail byte raw, waits until the last has left
// the read stage, then sends the end marker; an empty flush sends only the marker
// output register and read stage stall on dst_ready; src_ready is high only
// while the sequencer is idle; the group store needs no clearing after reset
//
`default_nettype none
`include "bitmap_byte_suppressor_defines.svh"

module bitmap_byte_suppressor
	import bbs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      src_valid,
	output logic           src_ready,
	input  wire in_item_t  src_item,
	output logic           dst_valid,
	input  wire logic      dst_ready,
	output out_item_t      dst_item,
	input  wire logic      cfg_we,
	input  wire logic [7:0] cfg_wdata
);

	// leading entry of a pending mask, entry 0 at the msb
	function automatic logic [IDX_W-1:0] first_entry(input logic [GROUP_SIZE-1:0] mask);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
			if (mask[GROUP_SIZE-1-i]) begin
				idx = IDX_W'(i);
			end
		end
		return idx;
	endfunction

	seq_state_t state_q, state_d;

	logic [7:0]            supp_q;
	logic [IDX_W-1:0]      fill_q;
	logic [GROUP_SIZE-1:0] pres_q;
	logic [GROUP_SIZE-1:0] rem_q;
	logic                  raw_q;

	logic [7:0]            grp_mem [GROUP_SIZE];
	logic [7:0]            rdata_s1;
	logic                  valid_s1;
	logic [1:0]            kind_s1;
	logic                  last_s1;

	logic                  dst_valid_q;
	out_item_t             dst_item_q;

	logic                  acc;
	logic                  out_free;
	logic                  s1_move;
	logic                  s1_free;
	logic                  rd_en;
	logic                  map_load;
	logic                  mark_load;
	logic [IDX_W-1:0]      rd_idx;
	logic [GROUP_SIZE-1:0] rem_clr;
	logic [GROUP_SIZE-1:0] pres_nx;

	// handshake and stage movement
	assign src_ready = (state_q == ST_IDLE);
	assign acc       = src_valid && src_ready;
	assign out_free  = !dst_valid_q || dst_ready;
	assign s1_move   = valid_s1 && out_free;
	assign s1_free   = !valid_s1 || s1_move;

	// next entry to read and mask with it retired
	assign rd_idx  = first_entry(rem_q);
	assign rem_clr = rem_q & ~(GROUP_SIZE'(8'h80) >> rd_idx);

	// presence map with the incoming byte folded in
	assign pres_nx = pres_q |
		((src_item.data_byte != supp_q) ? (GROUP_SIZE'(8'h80) >> fill_q) : '0);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer next state and strobes
	always_comb begin
		state_d   = state_q;
		map_load  = 1'b0;
		mark_load = 1'b0;
		rd_en     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (src_valid) begin
					if (src_item.cmd == CMD_FLUSH) begin
						state_d = (fill_q == '0) ? ST_MARK : ST_SCAN;
					end else if (fill_q == LAST_IDX) begin
						state_d = ST_MAP;
					end
				end
			end
			ST_MAP: begin
				if (out_free && !valid_s1) begin
					map_load = 1'b1;
					state_d  = (rem_q == '0) ? ST_IDLE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (s1_free) begin
					rd_en = 1'b1;
					if (rem_clr == '0) begin
						state_d = raw_q ? ST_MARK : ST_IDLE;
					end
				end
			end
			ST_MARK: begin
				if (out_free && !valid_s1) begin
					mark_load = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// suppressed byte register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supp_q <= '0;
		end else if (cfg_we) begin
			supp_q <= cfg_wdata;
		end
	end

	// group fill, presence map and pending entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pres_q <= '0;
			rem_q  <= '0;
			raw_q  <= 1'b0;
		end else begin
			if (acc && src_item.cmd == CMD_DATA) begin
				if (fill_q == LAST_IDX) begin
					fill_q <= '0;
					pres_q <= '0;
					rem_q  <= pres_nx;
					raw_q  <= 1'b0;
				end else begin
					fill_q <= fill_q + IDX_W'(1);
					pres_q <= pres_nx;
				end
			end else if (acc) begin
				pres_q <= '0;
				rem_q  <= ~({GROUP_SIZE{1'b1}} >> fill_q);
				raw_q  <= 1'b1;
			end
			if (rd_en) begin
				rem_q <= rem_clr;
			end
			if (mark_load) begin
				fill_q <= '0;
			end
		end
	end

	// group store write port
	always_ff @(posedge clk) begin
		if (acc && src_item.cmd == CMD_DATA) begin
			grp_mem[fill_q] <= src_item.data_byte;
		end
	end

	// group store read port, data held while the stage stalls
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= grp_mem[rd_idx];
			kind_s1  <= raw_q ? KIND_RAW : KIND_LIT;
			last_s1  <= !raw_q && (rem_clr == '0);
		end
	end

	// read stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rd_en) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid_q <= 1'b0;
		end else if (s1_move || map_load || mark_load) begin
			dst_valid_q <= 1'b1;
		end else if (dst_ready) begin
			dst_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (s1_move) begin
			dst_item_q.out_kind <= kind_s1;
			dst_item_q.out_byte <= rdata_s1;
			dst_item_q.last     <= last_s1;
		end else if (map_load) begin
			dst_item_q.out_kind <= KIND_MAP;
			dst_item_q.out_byte <= rem_q;
			dst_item_q.last     <= (rem_q == '0);
		end else if (mark_load) begin
			dst_item_q.out_kind <= KIND_END;
			dst_item_q.out_byte <= END_MARK_BASE | {5'd0, fill_q};
			dst_item_q.last     <= 1'b1;
		end
	end

	assign dst_valid = dst_valid_q;
	assign dst_item  = dst_item_q;

	// checks
	`ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !out_free, valid_s1 && $stable(rdata_s1))
	`ASSERT_IMPLY(a_map_fill, clk, arst_n, state_q == ST_MAP, fill_q == '0)
	`ASSERT_IMPLY(a_scan_pending, clk, arst_n, state_q == ST_SCAN, rem_q != '0)
	`ASSERT_IMPLY(a_mark_done, clk, arst_n, state_q == ST_MARK, rem_q == '0 && raw_q)
	`ASSERT_NEXT(a_group_map, clk, arst_n, acc && src_item.cmd == CMD_DATA && fill_q == LAST_IDX, state_q == ST_MAP)

endmodule

`default_nettype wire

### tb/tb_bitmap_byte_suppressor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bitmap_byte_suppressor
// self-checking bench for the bitmap byte suppressor: a directed table then
// random byte streams under several suppressed values, each accepted transfer
// run through a local predictor and every result compared field by field
// ----------------------------------------------------------------------------

module tb_bitmap_byte_suppressor;
	import bbs_pkg::*;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_TAIL    = 6;
	localparam int PHASE_ITEMS   = 66;
	localparam int BURST_ITEMS   = 40;

	// one row of the directed table
	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t res;
	} stim_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      src_valid = 1'b0;
	logic      src_ready;
	in_item_t  src_item = '0;
	logic      dst_valid;
	logic      dst_ready = 1'b0;
	out_item_t dst_item;
	logic      cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;

	// predictor state
	logic [7:0] supp_val = 8'h00;
	logic [7:0] grp_bytes [GROUP_SIZE];
	int         grp_fill = 0;
	logic [7:0] grp_map = 8'h00;

	out_item_t  exp_q [$];
	stim_row_t  dir_rows [$];

	int errors = 0;
	int cycles = 0;
	int items_sent = 0;
	int results_seen = 0;
	int groups_done = 0;
	int flushes_done = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_reqs = 0;
	int hold_done = 0;
	int hold_left = 0;

	bitmap_byte_suppressor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_item  (src_item),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_item  (dst_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_bitmap_byte_suppressor: errors");
			$finish;
		end
	end

	function automatic out_item_t mk_result(input logic [1:0] kind, input logic [7:0] b);
		out_item_t r;
		r.out_kind = kind;
		r.out_byte = b;
		r.last     = 1'b0;
		return r;
	endfunction

	// expected output of one accepted transfer, appended to exp_q
	function automatic void predict_suppression(input in_item_t it);
		int first;
		int i;
		first = exp_q.size();
		if (it.cmd == CMD_DATA) begin
			grp_bytes[grp_fill] = it.data_byte;
			if (it.data_byte != supp_val)
				grp_map[7 - grp_fill] = 1'b1;
			grp_fill++;
			if (grp_fill == GROUP_SIZE) begin
				exp_q.push_back(mk_result(KIND_MAP, grp_map));
				for (i = 0; i < GROUP_SIZE; i++)
					if (grp_map[7 - i])
						exp_q.push_back(mk_result(KIND_LIT, grp_bytes[i]));
				grp_fill = 0;
				grp_map  = 8'h00;
				groups_done++;
			end
		end else begin
			// partial group goes out raw, then the end marker
			for (i = 0; i < grp_fill; i++)
				exp_q.push_back(mk_result(KIND_RAW, grp_bytes[i]));
			exp_q.push_back(mk_result(KIND_END, END_MARK_BASE | 8'(grp_fill)));
			grp_fill = 0;
			grp_map  = 8'h00;
			flushes_done++;
		end
		if (exp_q.size() > first)
			exp_q[exp_q.size() - 1].last = 1'b1;
	endfunction

	function automatic stim_row_t row(input logic cmd, input logic [7:0] b, input bit typed,
			input logic [1:0] kind, input logic [7:0] ob);
		stim_row_t r;
		r.item.cmd       = cmd;
		r.item.data_byte = b;
		r.typed          = typed;
		r.res.out_kind   = kind;
		r.res.out_byte   = ob;
		r.res.last       = 1'b1;
		return r;
	endfunction

	// bytes biased towards the suppressed value and the extremes
	function automatic logic [7:0] pick_byte();
		logic [7:0] b;
		case ($urandom_range(9))
			0, 1, 2, 3: b = supp_val;
			4: b = 8'h00;
			5: b = 8'hFF;
			default: b = 8'($urandom_range(255));
		endcase
		return b;
	endfunction

	// sender: drop valid and idle, n setting the length of the pause
	task automatic pause(input int n);
		@(negedge clk);
		src_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// offer one item and hold it until the transfer
	task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_res);
		if ($urandom_range(99) < tx_idle_pct)
			pause($urandom_range(1, 6));
		@(negedge clk);
		src_valid <= 1'b1;
		src_item  <= it;
		do @(posedge clk); while (!src_ready);
		predict_suppression(it);
		if (typed)
			exp_q[exp_q.size() - 1] = typed_res;
		items_sent++;
	endtask

	task automatic send_random();
		in_item_t it;
		it.cmd       = ($urandom_range(11) == 0) ? CMD_FLUSH : CMD_DATA;
		it.data_byte = pick_byte();
		send_item(it, 1'b0, '0);
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain();
		pause(1);
		while (exp_q.size() != 0) @(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	task automatic write_suppressed(input logic [7:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		supp_val = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// receiver: random back-pressure, or a long hold when requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			dst_ready <= 1'b0;
			hold_left--;
		end else if (hold_reqs != hold_done) begin
			hold_done = hold_reqs;
			hold_left = HOLD_CYCLES - 1;
			dst_ready <= 1'b0;
		end else begin
			dst_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && dst_valid && dst_ready) begin
			if (exp_q.size() == 0) begin
				errors++;
				$error("unexpected result: out_kind %0d out_byte %02h last %0b",
					dst_item.out_kind, dst_item.out_byte, dst_item.last);
			end else begin
				want = exp_q.pop_front();
				results_seen++;
				if (dst_item.out_kind !== want.out_kind) begin
					errors++;
					$error("out_kind: expected %0d, actual %0d", want.out_kind,
						dst_item.out_kind);
				end
				if (dst_item.out_byte !== want.out_byte) begin
					errors++;
					$error("out_byte: expected %02h, actual %02h", want.out_byte,
						dst_item.out_byte);
				end
				if (dst_item.last !== want.last) begin
					errors++;
					$error("last: expected %0b, actual %0b", want.last, dst_item.last);
				end
			end
		end
	end

	// stimulus
	initial begin
		logic [7:0] phase_sup [6];
		logic [7:0] tail_bytes [7];
		in_item_t   it;
		int i;
		int ph;

		tail_bytes = '{8'hA5, 8'h5A, 8'hFF, 8'h00, 8'h01, 8'h80, 8'hFE};
		phase_sup  = '{8'hFF, 8'h00, 8'($urandom_range(255)), 8'h80, 8'h01,
			8'($urandom_range(255))};

		// directed table, suppressed byte at its reset value of zero
		dir_rows.push_back(row(CMD_FLUSH, 8'h00, 1'b1, KIND_END, 8'h30));
		for (i = 0; i < GROUP_SIZE; i++)
			dir_rows.push_back(row(CMD_DATA, 8'h00, i == GROUP_SIZE - 1, KIND_MAP, 8'h00));
		for (i = 0; i < GROUP_SIZE; i++)
			dir_rows.push_back(row(CMD_DATA, 8'hFF, i == GROUP_SIZE - 1, KIND_LIT, 8'hFF));
		for (i = 0; i < 7; i++)
			dir_rows.push_back(row(CMD_DATA, tail_bytes[i], 1'b0, KIND_MAP, 8'h00));
		dir_rows.push_back(row(CMD_FLUSH, 8'hC3, 1'b1, KIND_END, 8'h37));

		tx_idle_pct = 11;
		rx_idle_pct = 73;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (dir_rows[r])
			send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].res);

		// random streams, a new suppressed value per phase, often mid-group
		for (ph = 0; ph < 6; ph++) begin
			if (ph < 2) begin
				tx_idle_pct = 11;
				rx_idle_pct = 73;
			end else if (ph < 4) begin
				tx_idle_pct = 73;
				rx_idle_pct = 11;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			drain();
			write_suppressed(phase_sup[ph]);

			// long receiver hold while the sender keeps pushing kept bytes
			if (ph == 2) begin
				tx_idle_pct = 0;
				hold_reqs++;
				for (i = 0; i < BURST_ITEMS; i++) begin
					it.cmd       = CMD_DATA;
					it.data_byte = ~supp_val ^ 8'($urandom_range(1) << $urandom_range(7));
					send_item(it, 1'b0, '0);
				end
				drain();
				tx_idle_pct = 73;
			end

			for (i = 0; i < PHASE_ITEMS; i++)
				send_random();
		end

		drain();
		$display("%0d items sent, %0d results checked: %0d full groups, %0d flushes,",
			items_sent, results_seen, groups_done, flushes_done);
		$display("seven suppressed byte settings, both idling patterns and a long output hold");
		if (errors == 0 && exp_q.size() == 0)
			$display("tb_bitmap_byte_suppressor: clean");
		else
			$display("tb_bitmap_byte_suppressor: errors");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/bbs_pkg.sv
rtl/bitmap_byte_suppressor.sv
tb/tb_bitmap_byte_suppressor.sv
